### hw/rtl/dobf_pkg.sv
// Package for the drop-oldest byte FIFO: ring geometry, field widths,
// operation codes and the result metadata struct.
// No dependencies.
package dobf_pkg;

  // Ring geometry (power of two)
  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PTR_W  = ADDR_W + 1;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned FILL_W = 13;
  localparam int unsigned CNT_W  = 64;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result fields known at accept time; the byte itself comes from the RAM
  typedef struct packed {
    logic              rd;
    logic [FILL_W-1:0] fill;
    cnt_t              pushed;
    cnt_t              dropped;
  } res_meta_t;

endpackage

### hw/rtl/dobf_if.sv
// Valid/ready channel interfaces for the drop-oldest byte FIFO.
// Depends on dobf_pkg.
interface dobf_in_if
  import dobf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface dobf_out_if
  import dobf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_byte;
  logic              read_valid;
  logic [FILL_W-1:0] fill_level;
  logic [CNT_W-1:0]  pushed_total;
  logic [CNT_W-1:0]  dropped_total;

  modport source (output valid, output read_byte, output read_valid, output fill_level,
                  output pushed_total, output dropped_total, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input fill_level,
                  input pushed_total, input dropped_total, output ready);
endinterface

### hw/rtl/dobf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dobf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/drop_oldest_byte_fifo_top.sv
// Drop-oldest byte FIFO top level.
// Depends on dobf_pkg, dobf_if (channel interfaces) and dobf_ram.
//
// Byte FIFO over a ring of DEPTH entries that overwrites its oldest byte when a
// push finds it full. Each item is a push, a pop or a clear and yields exactly
// one result item carrying the popped byte (if any), the fill level after the
// item and wrapping 64-bit totals of pushed and dropped bytes. The block takes
// one item per cycle as long as the output takes one result per cycle.
// Pointers and totals live in registers and are updated at the edge that
// accepts the item. The bytes sit in one RAM with one write port (pushes) and
// one registered read port (pops). A one-entry pending stage holds each item
// during the RAM read, which happens at the edge that accepts it; the result
// moves on into the output register once that register is empty or is being
// taken. While that stage is occupied, input ready is low exactly when the
// output register holds a result that is not taken, so a stalled output stops
// the input after one more item. No clearing pass is needed after reset: a pop
// only reads entries that a push wrote.
module drop_oldest_byte_fifo_top
  import dobf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dobf_in_if.sink    in_ch,
  dobf_out_if.source out_ch
);

  // Pointer and total state
  ptr_t wp_r, wp_nxt;
  ptr_t rp_r, rp_nxt;
  cnt_t pushed_r, pushed_nxt;
  cnt_t dropped_r, dropped_nxt;

  // Pending stage (waits for RAM read data) and output register
  logic      p_valid_r;
  res_meta_t p_meta_r;
  res_meta_t meta_nxt;
  logic      out_valid_r;
  byte_t     out_byte_r;
  res_meta_t out_meta_r;

  logic  acc, can_move, in_rdy;
  op_t   op;
  ptr_t  fill, fill_nxt;
  logic  full, empty;
  logic  ram_we, ram_re, rd;
  byte_t ram_rdata;

  // Handshake
  assign can_move = !out_valid_r || out_ch.ready;
  assign in_rdy   = !p_valid_r || can_move;
  assign acc      = in_ch.valid && in_rdy;
  assign op       = op_t'(in_ch.operation);

  assign fill  = wp_r - rp_r;
  assign full  = (fill == ptr_t'(DEPTH));
  assign empty = (fill == '0);

  // Item decode and state update
  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    pushed_nxt  = pushed_r;
    dropped_nxt = dropped_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    rd          = 1'b0;
    if (acc) begin
      case (op)
        OP_PUSH: begin
          if (full) begin
            rp_nxt      = rp_r + ptr_t'(1);
            dropped_nxt = dropped_r + cnt_t'(1);
          end
          ram_we     = 1'b1;
          wp_nxt     = wp_r + ptr_t'(1);
          pushed_nxt = pushed_r + cnt_t'(1);
        end
        OP_POP: begin
          if (!empty) begin
            ram_re = 1'b1;
            rd     = 1'b1;
            rp_nxt = rp_r + ptr_t'(1);
          end
        end
        OP_CLEAR: begin
          rp_nxt = wp_r;
        end
        default: begin
          // unused code: no state change
        end
      endcase
    end
  end

  assign fill_nxt = wp_nxt - rp_nxt;

  always_comb begin
    meta_nxt.rd      = rd;
    meta_nxt.fill    = FILL_W'(fill_nxt);
    meta_nxt.pushed  = pushed_nxt;
    meta_nxt.dropped = dropped_nxt;
  end

  // Byte store
  dobf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r[ADDR_W-1:0]),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (rp_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      pushed_r    <= '0;
      dropped_r   <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      pushed_r  <= pushed_nxt;
      dropped_r <= dropped_nxt;
      if (in_rdy) begin
        p_valid_r <= acc;
      end
      if (can_move) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      p_meta_r <= meta_nxt;
    end
    if (can_move && p_valid_r) begin
      out_meta_r <= p_meta_r;
      out_byte_r <= p_meta_r.rd ? ram_rdata : '0;
    end
  end

  // Ports
  assign in_ch.ready          = in_rdy;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_byte     = out_byte_r;
  assign out_ch.read_valid    = out_meta_r.rd;
  assign out_ch.fill_level    = out_meta_r.fill;
  assign out_ch.pushed_total  = out_meta_r.pushed;
  assign out_ch.dropped_total = out_meta_r.dropped;

`ifndef SYNTHESIS
  // Ring never holds more than DEPTH bytes
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= ptr_t'(DEPTH))
    else $error("fill level beyond ring depth");

  // Each accepted push bumps the pushed total by exactly one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_PUSH) |=> (pushed_r == $past(pushed_r) + cnt_t'(1)))
    else $error("pushed total not incremented");

  // A pop of a non-empty ring lands in the pending stage as a valid read
  a_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_POP && !empty) |=> (p_valid_r && p_meta_r.rd))
    else $error("pop read lost");

  // Pending stage is never overwritten while it cannot drain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !can_move) |-> !acc)
    else $error("pending item overwritten");
`endif

endmodule
